[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions, sampled on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent must be followed in the same cycle by the consequent.
`define CBT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Antecedent must be followed in the next cycle by the consequent.
`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// cbt_pkg
// Types, codes and helpers shared by the chunked body tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

	localparam int unsigned RemW = 64;

	typedef enum logic [12:0] {
		PH_SIZE_FIRST  = 13'h0001,
		PH_SIZE        = 13'h0002,
		PH_EXT         = 13'h0004,
		PH_SIZE_LF     = 13'h0008,
		PH_DATA        = 13'h0010,
		PH_DATA_CR     = 13'h0020,
		PH_DATA_LF     = 13'h0040,
		PH_TRL_START   = 13'h0080,
		PH_TRL_LINE    = 13'h0100,
		PH_TRL_END_LF  = 13'h0200,
		PH_TRL_LINE_LF = 13'h0400,
		PH_DONE        = 13'h0800,
		PH_ERROR       = 13'h1000
	} cbt_phase_t;

	localparam logic [1:0] ST_MORE  = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic FN_BYTE    = 1'b0;
	localparam logic FN_RESTART = 1'b1;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_CTL_LIMIT = 8'h20;

	typedef struct packed {
		logic        ok;
		logic [3:0]  value;
	} cbt_hex_t;

	typedef struct packed {
		cbt_phase_t          phase;
		logic [RemW-1:0]     remaining;
		logic [1:0]          status;
	} cbt_next_t;

	function automatic cbt_hex_t hex_decode(input logic [7:0] b);
		cbt_hex_t r;
		r.ok    = 1'b1;
		r.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.value = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.value = 4'(b - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/cbt_intf.sv]
// ----------------------------------------------------------------------------
// cbt_intf
// Valid/ready channels for body bytes in and status out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbt_byte_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	logic       last_of_call;

	modport source (output valid, func, data_byte, last_of_call, input ready);
	modport sink   (input valid, func, data_byte, last_of_call, output ready);
endinterface

interface cbt_status_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;

	modport source (output valid, status, input ready);
	modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/cbt_next.sv]
// ----------------------------------------------------------------------------
// cbt_next
// Framing step: next phase, next size/countdown and the status for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_next (
	input  var cbt_pkg::cbt_phase_t      phase,
	input  var logic [cbt_pkg::RemW-1:0] remaining,
	input  var logic                     func,
	input  var logic [7:0]               data_byte,
	output var cbt_pkg::cbt_next_t       nxt
);

	cbt_pkg::cbt_hex_t        hex;
	cbt_pkg::cbt_phase_t      ph;
	logic [cbt_pkg::RemW-1:0] rem;
	logic                     is_ctl;

	assign hex    = cbt_pkg::hex_decode(data_byte);
	assign is_ctl = data_byte < cbt_pkg::CH_CTL_LIMIT;

	always_comb begin
		ph  = phase;
		rem = remaining;
		unique case (phase)
			cbt_pkg::PH_SIZE_FIRST: begin
				if (hex.ok) begin
					rem = {{(cbt_pkg::RemW-4){1'b0}}, hex.value};
					ph  = cbt_pkg::PH_SIZE;
				end else begin
					ph = cbt_pkg::PH_ERROR;
				end
			end
			cbt_pkg::PH_SIZE: begin
				if (!hex.ok) begin
					if (data_byte == cbt_pkg::CH_SEMI) ph = cbt_pkg::PH_EXT;
					else if (data_byte == cbt_pkg::CH_CR) ph = cbt_pkg::PH_SIZE_LF;
					else ph = cbt_pkg::PH_ERROR;
				end else if (remaining[cbt_pkg::RemW-1 -: 4] != 4'd0) begin
					// another digit would shift bits out of the top nibble
					ph = cbt_pkg::PH_ERROR;
				end else begin
					rem = {remaining[cbt_pkg::RemW-5:0], hex.value};
				end
			end
			cbt_pkg::PH_EXT: begin
				if (data_byte == cbt_pkg::CH_CR) ph = cbt_pkg::PH_SIZE_LF;
				else if (data_byte == cbt_pkg::CH_LF) ph = cbt_pkg::PH_ERROR;
			end
			cbt_pkg::PH_SIZE_LF: begin
				if (data_byte != cbt_pkg::CH_LF) ph = cbt_pkg::PH_ERROR;
				else if (remaining == '0) ph = cbt_pkg::PH_TRL_START;
				else ph = cbt_pkg::PH_DATA;
			end
			cbt_pkg::PH_DATA: begin
				if (remaining != '0) rem = remaining - 1'b1;
				if (remaining <= {{(cbt_pkg::RemW-1){1'b0}}, 1'b1}) ph = cbt_pkg::PH_DATA_CR;
			end
			cbt_pkg::PH_DATA_CR: begin
				ph = (data_byte == cbt_pkg::CH_CR) ? cbt_pkg::PH_DATA_LF : cbt_pkg::PH_ERROR;
			end
			cbt_pkg::PH_DATA_LF: begin
				if (data_byte != cbt_pkg::CH_LF) begin
					ph = cbt_pkg::PH_ERROR;
				end else begin
					ph  = cbt_pkg::PH_SIZE_FIRST;
					rem = '0;
				end
			end
			cbt_pkg::PH_TRL_START: begin
				if (data_byte == cbt_pkg::CH_CR) ph = cbt_pkg::PH_TRL_END_LF;
				else if (is_ctl) ph = cbt_pkg::PH_ERROR;
				else ph = cbt_pkg::PH_TRL_LINE;
			end
			cbt_pkg::PH_TRL_LINE: begin
				if (data_byte == cbt_pkg::CH_CR) ph = cbt_pkg::PH_TRL_LINE_LF;
				else if (is_ctl && data_byte != cbt_pkg::CH_TAB) ph = cbt_pkg::PH_ERROR;
			end
			cbt_pkg::PH_TRL_LINE_LF: begin
				ph = (data_byte == cbt_pkg::CH_LF) ? cbt_pkg::PH_TRL_START : cbt_pkg::PH_ERROR;
			end
			cbt_pkg::PH_TRL_END_LF: begin
				ph = (data_byte == cbt_pkg::CH_LF) ? cbt_pkg::PH_DONE : cbt_pkg::PH_ERROR;
			end
			cbt_pkg::PH_DONE: begin
				ph = cbt_pkg::PH_DONE;
			end
			cbt_pkg::PH_ERROR: begin
				ph = cbt_pkg::PH_ERROR;
			end
			default: begin
				ph = cbt_pkg::PH_ERROR;
			end
		endcase

		if (func == cbt_pkg::FN_RESTART) begin
			nxt.phase     = cbt_pkg::PH_SIZE_FIRST;
			nxt.remaining = '0;
			nxt.status    = cbt_pkg::ST_MORE;
		end else begin
			nxt.phase     = ph;
			nxt.remaining = rem;
			if (ph == cbt_pkg::PH_DONE) nxt.status = cbt_pkg::ST_END;
			else if (ph == cbt_pkg::PH_ERROR) nxt.status = cbt_pkg::ST_ERROR;
			else nxt.status = cbt_pkg::ST_MORE;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/chunked_body_tracker_top.sv]
// ----------------------------------------------------------------------------
// chunked_body_tracker_top
// Checks HTTP/1.1 chunked framing byte by byte and returns a status per byte.
// ----------------------------------------------------------------------------
// One status comes back for every request on byte_ch: 0 more bytes needed,
// 1 body ended, 2 framing error; end and error stick until a restart request
// (func = 1), which answers 0. Throughput is one byte per clock while status_ch
// is drained. The accepting edge loads the input register; the framing step
// (phase, 64-bit size/countdown) is then written into the status register.
// The phase/countdown registers feed back through combinational logic only,
// so back-to-back bytes never stall as long as status_ch is drained.
// last_of_call does not affect the status.
`default_nettype none

`include "assert_macros.svh"

module chunked_body_tracker_top (
	input  var logic           clk,
	input  var logic           arst_n,
	cbt_byte_if.sink           byte_ch,
	cbt_status_if.source       status_ch
);

	logic                     valid_s1;
	logic                     func_s1;
	logic [7:0]               byte_s1;
	cbt_pkg::cbt_phase_t      phase_q;
	logic [cbt_pkg::RemW-1:0] remaining_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic                     adv;
	logic                     proc;
	cbt_pkg::cbt_next_t       nxt;

	// stage 1 may move on when the result register is empty or being drained
	assign adv           = !out_valid_q || status_ch.ready;
	assign proc          = valid_s1 && adv;
	assign byte_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			func_s1 <= byte_ch.func;
			byte_s1 <= byte_ch.data_byte;
		end
	end

	cbt_next u_next (
		.phase     (phase_q),
		.remaining (remaining_q),
		.func      (func_s1),
		.data_byte (byte_s1),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cbt_pkg::PH_SIZE_FIRST;
			remaining_q <= '0;
		end else if (proc) begin
			phase_q     <= nxt.phase;
			remaining_q <= nxt.remaining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_q <= nxt.status;
		end
	end

	assign status_ch.valid  = out_valid_q;
	assign status_ch.status = status_q;

	`CBT_ASSERT_SAME(a_ready_only_stalls_when_full, !byte_ch.ready, valid_s1 && out_valid_q, "input stalled with room in the pipeline")
	`CBT_ASSERT_SAME(a_data_count_nonzero, phase_q == cbt_pkg::PH_DATA, remaining_q != '0, "payload phase with zero bytes due")
	`CBT_ASSERT_NEXT(a_done_sticks, phase_q == cbt_pkg::PH_DONE && !(proc && func_s1 == cbt_pkg::FN_RESTART), phase_q == cbt_pkg::PH_DONE, "ended body left done without restart")
	`CBT_ASSERT_NEXT(a_restart_answers_more, proc && func_s1 == cbt_pkg::FN_RESTART, status_q == cbt_pkg::ST_MORE && phase_q == cbt_pkg::PH_SIZE_FIRST, "restart did not clear tracker")

endmodule

`default_nettype wire

[tb/chunked_body_tracker_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_body_tracker_check
// Watches the byte and status channels, tracks the chunked framing on its own
// and compares every returned status with the one due for the oldest request.
// ----------------------------------------------------------------------------
module chunked_body_tracker_check
	import cbt_pkg::*;
(
	input  var logic clk,
	input  var logic arst_n,
	cbt_byte_if      byte_ch,
	cbt_status_if    status_ch,
	output int       fail_count,
	output int       pending
);

	localparam logic [4:0] HexNone  = 5'd16;
	localparam int         ShowMax  = 10;

	cbt_phase_t      trk_phase;
	logic [RemW-1:0] trk_left;
	logic [1:0]      status_due_q[$];
	logic [1:0]      due;
	int              shown;

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
		if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
		if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
		return HexNone;
	endfunction

	// Advances the framing state by one request and returns its status.
	function automatic logic [1:0] track_byte(input logic fn, input logic [7:0] b);
		logic [4:0] d;
		if (fn == FN_RESTART) begin
			trk_phase = PH_SIZE_FIRST;
			trk_left  = '0;
			return ST_MORE;
		end
		d = hex_digit(b);
		case (trk_phase)
			PH_SIZE_FIRST: begin
				if (d == HexNone) begin
					trk_phase = PH_ERROR;
				end else begin
					trk_left  = RemW'(d);
					trk_phase = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (d == HexNone) begin
					if (b == CH_SEMI) trk_phase = PH_EXT;
					else if (b == CH_CR) trk_phase = PH_SIZE_LF;
					else trk_phase = PH_ERROR;
				end else if (trk_left > ((~RemW'(0)) - RemW'(d)) / 16) begin
					// next digit would not fit in 64 bits
					trk_phase = PH_ERROR;
				end else begin
					trk_left = {trk_left[RemW-5:0], d[3:0]};
				end
			end
			PH_EXT: begin
				if (b == CH_CR) trk_phase = PH_SIZE_LF;
				else if (b == CH_LF) trk_phase = PH_ERROR;
			end
			PH_SIZE_LF: begin
				if (b != CH_LF) trk_phase = PH_ERROR;
				else trk_phase = (trk_left == '0) ? PH_TRL_START : PH_DATA;
			end
			PH_DATA: begin
				if (trk_left != '0) trk_left = trk_left - 1'b1;
				if (trk_left == '0) trk_phase = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				trk_phase = (b == CH_CR) ? PH_DATA_LF : PH_ERROR;
			end
			PH_DATA_LF: begin
				if (b != CH_LF) begin
					trk_phase = PH_ERROR;
				end else begin
					trk_phase = PH_SIZE_FIRST;
					trk_left  = '0;
				end
			end
			PH_TRL_START: begin
				if (b == CH_CR) trk_phase = PH_TRL_END_LF;
				else if (b < CH_CTL_LIMIT) trk_phase = PH_ERROR;
				else trk_phase = PH_TRL_LINE;
			end
			PH_TRL_LINE: begin
				if (b == CH_CR) trk_phase = PH_TRL_LINE_LF;
				else if (b < CH_CTL_LIMIT && b != CH_TAB) trk_phase = PH_ERROR;
			end
			PH_TRL_LINE_LF: begin
				trk_phase = (b == CH_LF) ? PH_TRL_START : PH_ERROR;
			end
			PH_TRL_END_LF: begin
				trk_phase = (b == CH_LF) ? PH_DONE : PH_ERROR;
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
				trk_phase = PH_ERROR;
			end
		endcase
		if (trk_phase == PH_DONE) return ST_END;
		if (trk_phase == PH_ERROR) return ST_ERROR;
		return ST_MORE;
	endfunction

	task automatic report_miss(input string what, input logic [1:0] e, input logic [1:0] a);
		fail_count++;
		if (shown < ShowMax) begin
			$display("%t %s: expected status %0d, got %0d", $realtime, what, e, a);
			shown++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_phase  = PH_SIZE_FIRST;
			trk_left   = '0;
			status_due_q.delete();
			fail_count = 0;
			pending    = 0;
			shown      = 0;
		end else begin
			if (status_ch.valid && status_ch.ready) begin
				if (status_due_q.size() == 0) begin
					report_miss("status with no request outstanding", 2'bxx, status_ch.status);
				end else begin
					due = status_due_q.pop_front();
					if (status_ch.status !== due)
						report_miss("status mismatch", due, status_ch.status);
				end
			end
			if (byte_ch.valid && byte_ch.ready)
				status_due_q.push_back(track_byte(byte_ch.func, byte_ch.data_byte));
			pending = status_due_q.size();
		end
	end

endmodule

[tb/chunked_body_tracker_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_body_tracker_top_test
// Feeds chunked bodies (clean, corrupted, truncated, oversized, noise) through
// the tracker under several idle patterns and back-pressure, and reports.
// ----------------------------------------------------------------------------
module chunked_body_tracker_top_test;
	import cbt_pkg::*;

	localparam int PhaseItems  = 300;
	localparam int StallLimit  = 5000;
	localparam int HoldCycles  = 300;
	localparam int SettleCycles = 20;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       last_of_call;
	} byte_req_t;

	logic      clk;
	logic      arst_n;
	int        fail_count;
	int        pending;
	byte_req_t req_plan_q[$];
	int        sent;
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        hold_req;
	int        quiet;

	cbt_byte_if   byte_ch();
	cbt_status_if status_ch();

	chunked_body_tracker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.status_ch (status_ch)
	);

	chunked_body_tracker_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.status_ch  (status_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + 8'(v);
		if ($urandom_range(1)) return 8'h61 + 8'(v) - 8'd10;
		return 8'h41 + 8'(v) - 8'd10;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		req_plan_q.push_back('{FN_BYTE, b, ($urandom_range(3) == 0)});
	endtask

	task automatic add_restart();
		req_plan_q.push_back('{FN_RESTART, rand_byte(), logic'($urandom_range(1))});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_size(input logic [63:0] v);
		int n;
		n = 1;
		while (n < 16 && (v >> (4 * n)) != 0) n++;
		repeat ($urandom_range(2)) add_byte(hex_char(4'h0));
		for (int i = n - 1; i >= 0; i--) add_byte(hex_char(v[4 * i +: 4]));
	endtask

	// optional chunk extension, any bytes but CR/LF
	task automatic add_ext();
		logic [7:0] b;
		if ($urandom_range(2) == 0) begin
			add_byte(CH_SEMI);
			repeat ($urandom_range(4)) begin
				b = rand_byte();
				while (b == CH_CR || b == CH_LF) b = rand_byte();
				add_byte(b);
			end
		end
	endtask

	task automatic add_body();
		int len;
		repeat ($urandom_range(3)) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
			add_size(64'(len));
			add_ext();
			add_text("\r\n");
			repeat (len) add_byte(rand_byte());
			add_text("\r\n");
		end
		add_size(64'd0);
		add_ext();
		add_text("\r\n");
		repeat ($urandom_range(2)) begin
			add_byte(8'($urandom_range(255, 32)));
			repeat ($urandom_range(5))
				add_byte(($urandom_range(5) == 0) ? CH_TAB : 8'($urandom_range(255, 32)));
			add_text("\r\n");
		end
		add_text("\r\n");
	endtask

	task automatic add_oversize();
		case ($urandom_range(2))
			0: begin
				repeat (16) add_byte(hex_char(4'hF));
				add_byte(hex_char(4'($urandom_range(15))));
			end
			1: begin
				add_byte(hex_char(4'h1));
				repeat (15) add_byte(hex_char(4'h0));
				add_byte(hex_char(4'($urandom_range(15))));
			end
			default: begin
				// largest size that still fits, then a few payload bytes
				add_byte(hex_char(4'h0));
				repeat (16) add_byte(hex_char(4'hF));
				add_text("\r\n");
				repeat ($urandom_range(4, 1)) add_byte(rand_byte());
			end
		endcase
	endtask

	task automatic add_scenario();
		int pick;
		int start;
		pick  = $urandom_range(99);
		start = req_plan_q.size();
		if (pick < 55) begin
			add_body();
			repeat ($urandom_range(2)) add_byte(rand_byte());
		end else if (pick < 70) begin
			add_body();
			req_plan_q[$urandom_range(req_plan_q.size() - 1, start)].data_byte = rand_byte();
		end else if (pick < 80) begin
			add_body();
			repeat ($urandom_range(req_plan_q.size() - start - 1, 1)) void'(req_plan_q.pop_back());
		end else if (pick < 90) begin
			repeat ($urandom_range(6, 1)) add_byte(rand_byte());
		end else begin
			add_oversize();
		end
		add_restart();
	endtask

	task automatic send_plan();
		byte_req_t r;
		while (req_plan_q.size() > 0) begin
			r = req_plan_q.pop_front();
			while ($urandom_range(99) < send_idle_pct) begin
				byte_ch.valid <= 1'b0;
				@(negedge clk);
			end
			byte_ch.valid        <= 1'b1;
			byte_ch.func         <= r.func;
			byte_ch.data_byte    <= r.data_byte;
			byte_ch.last_of_call <= r.last_of_call;
			@(posedge clk);
			while (!byte_ch.ready) @(posedge clk);
			@(negedge clk);
			sent++;
		end
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		status_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				status_ch.ready <= 1'b0;
			end else begin
				status_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (status_ch.valid && status_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= StallLimit) begin
			$display("[chunked_body_tracker_top] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int base;
		arst_n               = 1'b0;
		byte_ch.valid        = 1'b0;
		byte_ch.func         = FN_BYTE;
		byte_ch.data_byte    = 8'h00;
		byte_ch.last_of_call = 1'b0;
		send_idle_pct        = 0;
		recv_idle_pct        = 0;
		hold_req             = 1'b0;
		sent                 = 0;
		quiet                = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty body, stuck end, bad first char, LF in extension, one-byte chunk
		add_text("0\r\n\r\n");
		add_byte(8'hFF);
		add_restart();
		add_byte(8'h00);
		add_restart();
		add_text("1;\n");
		add_restart();
		add_text("1\r\nZ\r\n0\r\n\r\n");
		add_restart();
		send_plan();
		wait_drained();

		base = sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 67; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 67; end
				default: begin send_idle_pct = 37; recv_idle_pct = 37; end
			endcase
			if (ph == 0) hold_req = 1'b1;
			while (sent < base + (ph + 1) * PhaseItems) begin
				add_scenario();
				send_plan();
			end
			wait_drained();
		end

		repeat (SettleCycles) @(negedge clk);
		if (fail_count == 0) begin
			$display("[chunked_body_tracker_top] OK");
		end else begin
			$display("[chunked_body_tracker_top] ERROR");
		end
		$finish;
	end

endmodule
